### rtl/lgs_pkg.sv
package lgs_pkg;

	localparam int IDX_W    = 6;
	localparam int SIDE_W   = 7;
	localparam int ACT_W    = 2;
	localparam int SUM_W    = 4;
	localparam int MOD_W    = IDX_W + SIDE_W;
	localparam int S_DATA_W = 16;
	localparam int M_DATA_W = 8;
	localparam int APB_AW   = 3;
	localparam int APB_DW   = 32;

	localparam logic [SIDE_W-1:0] GRID_SIDE_RST = 7'd64;
	localparam logic [SIDE_W-1:0] MIN_SIDE      = 7'd3;

	localparam logic [SUM_W-1:0] BIRTH_SUM = 4'd3;
	localparam logic [SUM_W-1:0] KEEP_SUM  = 4'd2;

	localparam logic [ACT_W-1:0] ACT_WRITE = 2'd0;
	localparam logic [ACT_W-1:0] ACT_STEP  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;

	localparam logic REG_GRID_SIDE = 1'b0;

endpackage

### rtl/lgs_mod.sv
module lgs_mod (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [lgs_pkg::IDX_W-1:0]  x,
	input  logic [lgs_pkg::SIDE_W-1:0] n,
	output logic                      done,
	output logic [lgs_pkg::IDX_W-1:0]  rem
);
	import lgs_pkg::*;

	localparam int KW = $clog2(IDX_W);

	logic              busy_q;
	logic              done_q;
	logic [KW-1:0]     k_q;
	logic [IDX_W-1:0]  rem_q;
	logic [SIDE_W-1:0] n_q;
	logic [MOD_W-1:0]  dsub;

	// one quotient bit per cycle, restoring form
	assign dsub = MOD_W'(n_q) << k_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			k_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				k_q    <= KW'(IDX_W - 1);
			end else if (busy_q) begin
				k_q <= k_q - KW'(1);
				if (k_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= x;
			n_q   <= n;
		end else if (busy_q && (MOD_W'(rem_q) >= dsub)) begin
			rem_q <= rem_q - dsub[IDX_W-1:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

### rtl/lgs_mem.sv
module lgs_mem #(
	parameter int MAX_SIDE = 64,
	parameter int AW       = 6
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rd_en,
	input  logic [AW-1:0]       rd_addr,
	output logic [MAX_SIDE-1:0] rd_data,
	input  logic                wr_en,
	input  logic [AW-1:0]       wr_addr,
	input  logic [MAX_SIDE-1:0] wr_data
);
	logic [MAX_SIDE-1:0] mem [MAX_SIDE];
	logic [MAX_SIDE-1:0] rd_q;
	logic [MAX_SIDE-1:0] vld_q;
	logic                rdv_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// rows never written read as dead
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rdv_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rdv_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rdv_q ? rd_q : '0;

endmodule

### rtl/lgs_row.sv
module lgs_row #(
	parameter int MAX_SIDE = 64,
	parameter int AW       = 6
) (
	input  logic [MAX_SIDE-1:0] above,
	input  logic [MAX_SIDE-1:0] cur,
	input  logic [MAX_SIDE-1:0] below,
	input  logic [AW-1:0]       last,
	output logic [MAX_SIDE-1:0] nxt
);
	import lgs_pkg::*;

	for (genvar c = 0; c < MAX_SIDE; c++) begin : g_col
		logic             al, cl, bl;
		logic             ar, cr, br;
		logic [SUM_W-1:0] nsum;

		if (c == 0) begin : g_left_wrap
			assign al = above[last];
			assign cl = cur[last];
			assign bl = below[last];
		end else begin : g_left
			assign al = above[c-1];
			assign cl = cur[c-1];
			assign bl = below[c-1];
		end

		if (c == MAX_SIDE - 1) begin : g_right_wrap
			assign ar = above[0];
			assign cr = cur[0];
			assign br = below[0];
		end else begin : g_right
			assign ar = (AW'(c) == last) ? above[0] : above[c+1];
			assign cr = (AW'(c) == last) ? cur[0]   : cur[c+1];
			assign br = (AW'(c) == last) ? below[0] : below[c+1];
		end

		assign nsum = SUM_W'(al) + SUM_W'(above[c]) + SUM_W'(ar)
		            + SUM_W'(cl) + SUM_W'(cr)
		            + SUM_W'(bl) + SUM_W'(below[c]) + SUM_W'(br);

		// columns past the side keep their value
		assign nxt[c] = (AW'(c) > last) ? cur[c]
		              : ((nsum == BIRTH_SUM) || ((nsum == KEEP_SUM) && cur[c]));
	end

endmodule

### rtl/life_grid_generation_step.sv
// Toroidal life grid held in one row-wide synchronous memory, one row per word. The side is
// grid_side clamped to 3..MAX_SIDE, row and column are taken modulo the side by two restoring
// remainder units (one bit per cycle each); a cell write or read then reads the row, writes
// back or picks the cell, and registers its result. A generation streams the rows through the
// memory read port once each plus the last row twice, computing and writing back one row per
// cycle. One word is worked on at a time; the next word is taken while a result still waits on
// the output. The grid reads as all dead after reset with no clearing pass.
module life_grid_generation_step #(
	parameter int MAX_SIDE = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lgs_pkg::APB_AW-1:0]    paddr,
	input  logic [lgs_pkg::APB_DW-1:0]    pwdata,
	output logic [lgs_pkg::APB_DW-1:0]    prdata,
	output logic                          pready,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [lgs_pkg::S_DATA_W-1:0]  s_tdata,  // row, col, alive_in
	input  logic [lgs_pkg::ACT_W-1:0]     s_tuser,  // action
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [lgs_pkg::M_DATA_W-1:0]  m_tdata,  // alive_out
	output logic [lgs_pkg::ACT_W-1:0]     m_tuser   // done_action
);
	import lgs_pkg::*;

	localparam int AW = $clog2(MAX_SIDE);
	localparam int CW = $clog2(MAX_SIDE + 3);
	localparam int NW = (CW > SIDE_W) ? CW : SIDE_W;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MOD  = 3'd1;
	localparam logic [2:0] ST_RD   = 3'd2;
	localparam logic [2:0] ST_ADV  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0]          state_q;
	logic [SIDE_W-1:0]   gs_q;
	logic [ACT_W-1:0]    act_q;
	logic                alive_in_q;
	logic                res_alive_q;
	logic                m_valid_q;
	logic                m_alive_q;
	logic [ACT_W-1:0]    m_act_q;
	logic [NW-1:0]       cnt_q;
	logic [MAX_SIDE-1:0] top_q;
	logic [MAX_SIDE-1:0] mid_q;
	logic [MAX_SIDE-1:0] first_q;

	logic                in_acc;
	logic                cfg_we;
	logic [NW-1:0]       side;
	logic [NW-1:0]       side_m1;
	logic [NW-1:0]       cnt_m1;
	logic [NW-1:0]       cnt_m3;
	logic [AW-1:0]       last;
	logic                row_done;
	logic                col_done;
	logic [IDX_W-1:0]    row_m;
	logic [IDX_W-1:0]    col_m;
	logic [AW-1:0]       row_r;
	logic [AW-1:0]       col_r;
	logic                rd_en;
	logic [AW-1:0]       rd_addr;
	logic [MAX_SIDE-1:0] rd_row;
	logic                wr_en;
	logic [AW-1:0]       wr_addr;
	logic [MAX_SIDE-1:0] wr_data;
	logic [MAX_SIDE-1:0] cell_wr;
	logic [MAX_SIDE-1:0] below;
	logic [MAX_SIDE-1:0] next_row;
	logic                out_load;

	// config port
	assign pready = 1'b1;
	assign cfg_we = psel & penable & pwrite;
	assign prdata = (paddr[APB_AW-1] == REG_GRID_SIDE) ? APB_DW'(gs_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gs_q <= GRID_SIDE_RST;
		end else if (cfg_we && (paddr[APB_AW-1] == REG_GRID_SIDE)) begin
			gs_q <= pwdata[SIDE_W-1:0];
		end
	end

	always_comb begin
		if (gs_q < MIN_SIDE) begin
			side = NW'(MIN_SIDE);
		end else if (int'(gs_q) > MAX_SIDE) begin
			side = NW'(MAX_SIDE);
		end else begin
			side = NW'(gs_q);
		end
	end

	assign side_m1 = side - NW'(1);
	assign cnt_m1  = cnt_q - NW'(1);
	assign cnt_m3  = cnt_q - NW'(3);
	assign last    = side_m1[AW-1:0];

	assign in_acc   = s_tvalid & s_tready;
	assign s_tready = (state_q == ST_IDLE);

	lgs_mod u_row_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_acc),
		.x      (s_tdata[IDX_W-1:0]),
		.n      (side[SIDE_W-1:0]),
		.done   (row_done),
		.rem    (row_m)
	);

	lgs_mod u_col_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_acc),
		.x      (s_tdata[2*IDX_W-1:IDX_W]),
		.n      (side[SIDE_W-1:0]),
		.done   (col_done),
		.rem    (col_m)
	);

	assign row_r = AW'(row_m);
	assign col_r = AW'(col_m);

	lgs_mem #(
		.MAX_SIDE (MAX_SIDE),
		.AW       (AW)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_row),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	// last row wraps onto the saved old first row
	assign below = (cnt_q == side + NW'(2)) ? first_q : rd_row;

	lgs_row #(
		.MAX_SIDE (MAX_SIDE),
		.AW       (AW)
	) u_row (
		.above (top_q),
		.cur   (mid_q),
		.below (below),
		.last  (last),
		.nxt   (next_row)
	);

	always_comb begin
		cell_wr        = rd_row;
		cell_wr[col_r] = alive_in_q;
	end

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = row_r;
		wr_en   = 1'b0;
		wr_addr = row_r;
		wr_data = cell_wr;
		unique case (state_q)
			ST_MOD: begin
				rd_en = row_done & col_done;
			end
			ST_RD: begin
				wr_en = (act_q == ACT_WRITE);
			end
			ST_ADV: begin
				rd_en   = (cnt_q <= side);
				rd_addr = (cnt_q == '0) ? last : cnt_m1[AW-1:0];
				wr_en   = (cnt_q >= NW'(3));
				wr_addr = cnt_m3[AW-1:0];
				wr_data = next_row;
			end
			default: begin
			end
		endcase
	end

	assign out_load = (state_q == ST_DONE) && (!m_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						cnt_q <= '0;
						if ((s_tuser == ACT_WRITE) || (s_tuser == ACT_READ)) begin
							state_q <= ST_MOD;
						end else if (s_tuser == ACT_STEP) begin
							state_q <= ST_ADV;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_MOD: begin
					if (row_done && col_done) begin
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_DONE;
				end
				ST_ADV: begin
					cnt_q <= cnt_q + NW'(1);
					if (cnt_q == side + NW'(2)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			act_q       <= s_tuser;
			alive_in_q  <= s_tdata[2*IDX_W];
			res_alive_q <= 1'b0;
		end
		if (state_q == ST_RD) begin
			res_alive_q <= (act_q == ACT_READ) ? rd_row[col_r] : 1'b0;
		end
		if (state_q == ST_ADV) begin
			if (cnt_q == NW'(1)) begin
				top_q <= rd_row;
			end else if (cnt_q == NW'(2)) begin
				mid_q   <= rd_row;
				first_q <= rd_row;
			end else if ((cnt_q >= NW'(3)) && (cnt_q <= side + NW'(1))) begin
				top_q <= mid_q;
				mid_q <= rd_row;
			end
		end
		if (out_load) begin
			m_alive_q <= res_alive_q;
			m_act_q   <= act_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = M_DATA_W'(m_alive_q);
	assign m_tuser  = m_act_q;

endmodule

### test/life_grid_checker.sv
`timescale 1ns / 100ps

module life_grid_checker #(
	parameter int SIDE_MAX = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lgs_pkg::APB_AW-1:0]    paddr,
	input  logic [lgs_pkg::APB_DW-1:0]    pwdata,
	input  logic                          pready,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [lgs_pkg::S_DATA_W-1:0]  s_tdata,  // row, col, alive_in
	input  logic [lgs_pkg::ACT_W-1:0]     s_tuser,  // action
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [lgs_pkg::M_DATA_W-1:0]  m_tdata,  // alive_out
	input  logic [lgs_pkg::ACT_W-1:0]     m_tuser,  // done_action
	output int                            fail_count,
	output int                            pending
);
	import lgs_pkg::*;

	typedef struct packed {
		logic             alive_out;
		logic [ACT_W-1:0] done_action;
	} cell_word_t;

	logic [SIDE_MAX-1:0] cells [SIDE_MAX];
	logic [SIDE_W-1:0]   side_reg;
	cell_word_t          cell_words_due [$];
	int                  n_fail;

	function automatic int unsigned side_in_use(input logic [SIDE_W-1:0] s);
		if (s < MIN_SIDE)
			return MIN_SIDE;
		if (s > SIDE_MAX)
			return SIDE_MAX;
		return s;
	endfunction

	// whole generation from a snapshot of the old grid, cells past the side untouched
	task automatic next_generation(input int unsigned n);
		logic [SIDE_MAX-1:0] prev [SIDE_MAX];
		logic [SUM_W-1:0]    cnt;
		int unsigned         rr, cc;
		prev = cells;
		for (int unsigned r = 0; r < n; r++) begin
			for (int unsigned c = 0; c < n; c++) begin
				cnt = '0;
				for (int unsigned dr = 0; dr < 3; dr++) begin
					for (int unsigned dc = 0; dc < 3; dc++) begin
						if (!(dr == 1 && dc == 1)) begin
							rr = (r + n + dr - 1) % n;
							cc = (c + n + dc - 1) % n;
							cnt = cnt + prev[rr][cc];
						end
					end
				end
				cells[r][c] = (cnt == BIRTH_SUM) || (cnt == KEEP_SUM && prev[r][c]);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		cell_word_t  want;
		int unsigned n, r, c;
		if (!arst_n) begin
			for (int i = 0; i < SIDE_MAX; i++)
				cells[i] = '0;
			side_reg = GRID_SIDE_RST;
			cell_words_due.delete();
			n_fail = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr[APB_AW-1:2] == REG_GRID_SIDE)
				side_reg = pwdata[SIDE_W-1:0];

			if (m_tvalid && m_tready) begin
				if (cell_words_due.size() == 0) begin
					$error("unexpected word: alive_out %0d done_action %0d", m_tdata, m_tuser);
					n_fail++;
				end else begin
					want = cell_words_due.pop_front();
					if (m_tdata !== M_DATA_W'(want.alive_out)) begin
						$error("alive_out: expected %0d, actual %0d", want.alive_out, m_tdata);
						n_fail++;
					end
					if (m_tuser !== want.done_action) begin
						$error("done_action: expected %0d, actual %0d", want.done_action, m_tuser);
						n_fail++;
					end
				end
			end

			if (s_tvalid && s_tready) begin
				n = side_in_use(side_reg);
				r = s_tdata[IDX_W-1:0] % n;
				c = s_tdata[2*IDX_W-1:IDX_W] % n;
				want.alive_out = 1'b0;
				want.done_action = s_tuser;
				case (s_tuser)
					ACT_WRITE: cells[r][c] = s_tdata[2*IDX_W];
					ACT_STEP:  next_generation(n);
					ACT_READ:  want.alive_out = cells[r][c];
					default:   ;
				endcase
				cell_words_due.push_back(want);
			end

			fail_count <= n_fail;
			pending <= cell_words_due.size();
		end
	end

endmodule

### test/tb_life_grid_generation_step.sv
`timescale 1ns / 100ps

module tb_life_grid_generation_step;
	import lgs_pkg::*;

	localparam logic [ACT_W-1:0]  ACT_NONE       = 2'd3;
	localparam logic              REG_UNUSED     = 1'b1;
	localparam logic [APB_AW-1:0] ADDR_GRID_SIDE = {REG_GRID_SIDE, 2'b00};
	localparam logic [APB_AW-1:0] ADDR_UNUSED    = {REG_UNUSED, 2'b00};
	localparam int                SETTLE_CYCLES  = 100;
	localparam int                CYCLE_LIMIT    = 400000;
	localparam int                PHASE_WORDS    = 50;

	logic                clk;
	logic                arst_n   = 1'b0;
	logic                psel     = 1'b0;
	logic                penable  = 1'b0;
	logic                pwrite   = 1'b0;
	logic [APB_AW-1:0]   paddr    = '0;
	logic [APB_DW-1:0]   pwdata   = '0;
	logic [APB_DW-1:0]   prdata;
	logic                pready;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata  = '0;
	logic [ACT_W-1:0]    s_tuser  = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;
	logic [ACT_W-1:0]    m_tuser;

	int                  fail_count;
	int                  pending;
	int                  cycles = 0;
	bit                  gaps_on = 1'b0;
	int                  stall_left = 0;
	int unsigned         side_now;
	int unsigned         hot_row, hot_col;
	logic [SIDE_W-1:0]   phase_side [10];

	life_grid_generation_step dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	life_grid_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.pready     (pready),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// receiver back-pressure in bursts
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else if (gaps_on && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(0, 15);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic reg_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// tdata: row [5:0], col [11:6], alive_in [12]
	task automatic send_word(input logic [ACT_W-1:0] act, input int unsigned r,
			input int unsigned c, input logic a);
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= {3'b000, a, c[IDX_W-1:0], r[IDX_W-1:0]};
		do @(posedge clk); while (!s_tready);
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_side(input logic [SIDE_W-1:0] s);
		reg_write(ADDR_GRID_SIDE, {$urandom} & ~APB_DW'({SIDE_W{1'b1}}) | APB_DW'(s));
		if (s < MIN_SIDE)
			side_now = MIN_SIDE;
		else if (s > 64)
			side_now = 64;
		else
			side_now = s;
	endtask

	// mostly clustered cells so patterns live across generations
	task automatic send_random_word();
		int unsigned pick, r, c;
		logic [ACT_W-1:0] act;
		pick = $urandom_range(0, 99);
		if (pick < 45)
			act = ACT_WRITE;
		else if (pick < 80)
			act = ACT_READ;
		else if (pick < 96)
			act = ACT_STEP;
		else
			act = ACT_NONE;
		if ($urandom_range(0, 9) < 7) begin
			r = (hot_row + $urandom_range(0, 4)) % side_now;
			c = (hot_col + $urandom_range(0, 4)) % side_now;
			if (r + side_now <= 63 && $urandom_range(0, 3) == 0)
				r = r + side_now;
			if (c + side_now <= 63 && $urandom_range(0, 3) == 0)
				c = c + side_now;
		end else begin
			r = $urandom_range(0, 63);
			c = $urandom_range(0, 63);
		end
		send_word(act, r, c, $urandom_range(0, 9) < 5);
	endtask

	initial begin
		phase_side = '{7'd5, 7'd8, 7'd64, 7'd1, 7'd127, 7'd2, 7'd65, 7'd3, 7'd3, 7'd12};
		phase_side[7] = SIDE_W'($urandom_range(3, 16));
		side_now = 64;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// full side: corners, a row of three wrapped over the column edge, unused action
		send_word(ACT_READ, 0, 0, 1'b0);
		send_word(ACT_WRITE, 63, 63, 1'b1);
		send_word(ACT_READ, 63, 63, 1'b0);
		send_word(ACT_WRITE, 0, 63, 1'b1);
		send_word(ACT_WRITE, 0, 0, 1'b1);
		send_word(ACT_WRITE, 0, 1, 1'b1);
		send_word(ACT_NONE, 63, 63, 1'b1);
		send_word(ACT_STEP, 0, 0, 1'b0);
		send_word(ACT_READ, 63, 0, 1'b0);
		send_word(ACT_READ, 1, 0, 1'b0);
		send_word(ACT_READ, 0, 63, 1'b0);
		send_word(ACT_READ, 63, 63, 1'b0);
		send_word(ACT_WRITE, 63, 0, 1'b0);
		wait_idle();

		// side below range clamps to the smallest grid
		set_side(7'd0);
		send_word(ACT_WRITE, 63, 63, 1'b1);
		send_word(ACT_WRITE, 4, 4, 1'b1);
		send_word(ACT_WRITE, 2, 5, 1'b1);
		send_word(ACT_STEP, 0, 0, 1'b0);
		send_word(ACT_READ, 63, 63, 1'b0);
		send_word(ACT_READ, 1, 2, 1'b0);
		wait_idle();

		// side above range clamps to the largest grid, old outer cells reappear
		set_side(7'd127);
		send_word(ACT_READ, 63, 0, 1'b0);
		send_word(ACT_READ, 63, 1, 1'b0);
		send_word(ACT_READ, 2, 2, 1'b0);
		wait_idle();

		for (int ph = 0; ph < 10; ph++) begin
			if (ph == 4)
				reg_write(ADDR_UNUSED, $urandom);
			set_side(phase_side[ph]);
			gaps_on = (ph < 8) && (ph != 2);
			hot_row = $urandom_range(0, side_now - 1);
			hot_col = $urandom_range(0, side_now - 1);
			for (int i = 0; i < PHASE_WORDS; i++)
				send_random_word();
			wait_idle();
		end

		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

### sim.f
rtl/lgs_pkg.sv
rtl/lgs_mod.sv
rtl/lgs_mem.sv
rtl/lgs_row.sv
rtl/life_grid_generation_step.sv
test/life_grid_checker.sv
test/tb_life_grid_generation_step.sv
